/* rtl/epsm_pkg.sv */
package epsm_pkg;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RED_A,
        ST_RED_X,
        ST_RED_Y,
        ST_FIND,
        ST_INIT_X,
        ST_INIT_Y,
        ST_BIT,
        ST_DBL_X,
        ST_DBL_Y,
        ST_ADD_X,
        ST_ADD_Y,
        ST_PA_0,
        ST_TAKE_X,
        ST_TAKE_Y,
        ST_EQ_SUM,
        ST_EQ_CHK,
        ST_DB_M1,
        ST_DB_M2,
        ST_DB_A,
        ST_DB_Y2,
        ST_CH_S1,
        ST_CH_S2,
        ST_INV_0,
        ST_INV_1,
        ST_INV_2,
        ST_INV_3,
        ST_INV_LOOP,
        ST_INV_DIV,
        ST_INV_R1,
        ST_INV_R2,
        ST_INV_Q,
        ST_INV_M,
        ST_INV_S,
        ST_INV_U1,
        ST_INV_U2,
        ST_INV_END,
        ST_LAM,
        ST_X1,
        ST_X2,
        ST_X3,
        ST_Y1,
        ST_Y2,
        ST_Y3,
        ST_PUT_X,
        ST_PUT_Y,
        ST_PA_END,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOV,
        OP_QRED
    } t_op;

    typedef enum logic [4:0] {
        SEL_MD,
        SEL_ARED,
        SEL_BX,
        SEL_BY,
        SEL_AX,
        SEL_AY,
        SEL_TX,
        SEL_TY,
        SEL_LAM,
        SEL_T0,
        SEL_T1,
        SEL_T2,
        SEL_R1,
        SEL_R2,
        SEL_U1,
        SEL_U2,
        SEL_Q,
        SEL_ZERO,
        SEL_ONE,
        SEL_THREE
    } t_sel;

    localparam logic CFG_CURVE_A = 1'b0;
    localparam logic CFG_PRIME   = 1'b1;

    typedef struct packed {
        logic go;
        t_op  op;
        t_sel a;
        t_sel b;
        t_sel dst;
        logic load;
        logic k_shift;
        logic capture;
        logic res_inf;
        logic res_fault;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic eq_x;
        logic eq_y;
        logic t0_zero;
        logic r2_zero;
        logic md_lt2;
        logic k_zero;
        logic k_msb;
        logic kcnt_zero;
        logic pinf;
    } t_sts;

endpackage

/* rtl/epsm_dp.sv */
module epsm_dp
    import epsm_pkg::*;
#(
    parameter int FIELD_BITS  = 32,
    parameter int SCALAR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic [31:0] i_scalar,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic        i_point_at_infinity,
    output logic [31:0] o_result_x,
    output logic [31:0] o_result_y,
    output logic        o_result_infinity,
    output logic        o_fault
);

    localparam int W  = FIELD_BITS;
    localparam int S  = SCALAR_BITS;
    localparam int CW = (S > 1) ? $clog2(S) : 1;
    localparam int SW = $clog2(W);

    logic [31:0]   r_curve_a, r_prime;
    logic [W-1:0]  r_md, r_ared, r_bx, r_by, r_ax, r_ay, r_tx, r_ty;
    logic [W-1:0]  r_lam, r_t0, r_t1, r_t2, r_r1, r_r2, r_u1, r_u2, r_q;
    logic [S-1:0]  r_k;
    logic [CW-1:0] r_kcnt;
    logic          r_pinf;

    logic          r_busy, r_done;
    t_op           r_op;
    t_sel          r_dst;
    logic [W-1:0]  r_opa, r_opb, r_acc, r_rem;
    logic [SW-1:0] r_step;

    logic [31:0]   r_res_x, r_res_y;
    logic          r_res_inf, r_res_fault;

    logic [W-1:0]  va, vb, single_val, acc2, acc_n, rem_n, opa_n, wr_val;
    logic [W:0]    rem_sh;
    logic          ge, last, serial_go, wr_en;
    t_sel          wr_dst;

    function automatic logic [W-1:0] f_add(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
        logic [W-1:0] d;
        d = u - v;
        if (u < v) begin
            d = d + m;
        end
        return d;
    endfunction

    function automatic logic [W-1:0] f_rd(input t_sel s);
        logic [W-1:0] v;
        case (s)
            SEL_MD:    v = r_md;
            SEL_ARED:  v = r_ared;
            SEL_BX:    v = r_bx;
            SEL_BY:    v = r_by;
            SEL_AX:    v = r_ax;
            SEL_AY:    v = r_ay;
            SEL_TX:    v = r_tx;
            SEL_TY:    v = r_ty;
            SEL_LAM:   v = r_lam;
            SEL_T0:    v = r_t0;
            SEL_T1:    v = r_t1;
            SEL_T2:    v = r_t2;
            SEL_R1:    v = r_r1;
            SEL_R2:    v = r_r2;
            SEL_U1:    v = r_u1;
            SEL_U2:    v = r_u2;
            SEL_Q:     v = r_q;
            SEL_ZERO:  v = '0;
            SEL_ONE:   v = W'(1);
            SEL_THREE: begin
                if (r_md == W'(2)) begin
                    v = W'(1);
                end else if (r_md == W'(3)) begin
                    v = '0;
                end else begin
                    v = W'(3);
                end
            end
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        va = f_rd(i_cmd.a);
        vb = f_rd(i_cmd.b);
        case (i_cmd.op)
            OP_ADD:  single_val = f_add(va, vb, r_md);
            OP_SUB:  single_val = f_sub(va, vb, r_md);
            OP_QRED: single_val = (va >= r_md) ? (va - r_md) : va;
            default: single_val = va;
        endcase
        serial_go = i_cmd.go && (i_cmd.op == OP_MUL || i_cmd.op == OP_DIV);
    end

    // one quotient bit or one multiplier bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_opa[W-1]};
        ge     = rem_sh >= {1'b0, r_opb};
        rem_n  = ge ? W'(rem_sh - {1'b0, r_opb}) : rem_sh[W-1:0];
        opa_n  = {r_opa[W-2:0], ge};
        acc2   = f_add(r_acc, r_acc, r_md);
        acc_n  = r_opb[W-1] ? f_add(acc2, r_opa, r_md) : acc2;
        last   = r_busy && (r_step == SW'(W - 1));
    end

    always_comb begin
        wr_en  = 1'b0;
        wr_dst = i_cmd.dst;
        wr_val = single_val;
        if (i_cmd.go && !serial_go) begin
            wr_en = 1'b1;
        end else if (last) begin
            wr_en  = 1'b1;
            wr_dst = r_dst;
            wr_val = (r_op == OP_DIV) ? rem_n : acc_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_a <= '0;
            r_prime   <= 32'd3;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= (i_cmd.go && !serial_go) || last;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CURVE_A: r_curve_a <= i_cfg_wdata;
                    CFG_PRIME:   r_prime   <= i_cfg_wdata;
                    default:     ;
                endcase
            end
            if (serial_go) begin
                r_busy <= 1'b1;
            end else if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (serial_go) begin
            r_op   <= i_cmd.op;
            r_dst  <= i_cmd.dst;
            r_opa  <= va;
            r_opb  <= vb;
            r_acc  <= '0;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_op == OP_DIV) begin
                r_rem <= rem_n;
                r_opa <= opa_n;
            end else begin
                r_acc <= acc_n;
                r_opb <= r_opb << 1;
            end
        end
        if (last && r_op == OP_DIV) begin
            r_q <= opa_n;
        end
        if (i_cmd.load) begin
            r_md   <= W'(r_prime);
            r_ared <= W'(r_curve_a);
            r_bx   <= W'(i_point_x);
            r_by   <= W'(i_point_y);
            r_k    <= S'(i_scalar);
            r_kcnt <= CW'(S - 1);
            r_pinf <= i_point_at_infinity;
        end
        if (i_cmd.k_shift) begin
            r_k    <= r_k << 1;
            r_kcnt <= r_kcnt - 1'b1;
        end
        if (wr_en) begin
            case (wr_dst)
                SEL_ARED: r_ared <= wr_val;
                SEL_BX:   r_bx   <= wr_val;
                SEL_BY:   r_by   <= wr_val;
                SEL_AX:   r_ax   <= wr_val;
                SEL_AY:   r_ay   <= wr_val;
                SEL_TX:   r_tx   <= wr_val;
                SEL_TY:   r_ty   <= wr_val;
                SEL_LAM:  r_lam  <= wr_val;
                SEL_T0:   r_t0   <= wr_val;
                SEL_T1:   r_t1   <= wr_val;
                SEL_T2:   r_t2   <= wr_val;
                SEL_R1:   r_r1   <= wr_val;
                SEL_R2:   r_r2   <= wr_val;
                SEL_U1:   r_u1   <= wr_val;
                SEL_U2:   r_u2   <= wr_val;
                SEL_Q:    r_q    <= wr_val;
                default:  ;
            endcase
        end
        if (i_cmd.capture) begin
            r_res_fault <= i_cmd.res_fault;
            r_res_inf   <= i_cmd.res_inf && !i_cmd.res_fault;
            if (i_cmd.res_fault || i_cmd.res_inf) begin
                r_res_x <= '0;
                r_res_y <= '0;
            end else begin
                r_res_x <= 32'(r_ax);
                r_res_y <= 32'(r_ay);
            end
        end
    end

    always_comb begin
        o_sts.done      = r_done;
        o_sts.eq_x      = (r_ax == r_tx);
        o_sts.eq_y      = (r_ay == r_ty);
        o_sts.t0_zero   = (r_t0 == '0);
        o_sts.r2_zero   = (r_r2 == '0);
        o_sts.md_lt2    = (r_md < W'(2));
        o_sts.k_zero    = (r_k == '0);
        o_sts.k_msb     = r_k[S-1];
        o_sts.kcnt_zero = (r_kcnt == '0);
        o_sts.pinf      = r_pinf;
    end

    assign o_result_x        = r_res_x;
    assign o_result_y        = r_res_y;
    assign o_result_infinity = r_res_inf;
    assign o_fault           = r_res_fault;

endmodule

/* rtl/epsm_ctrl.sv */
module epsm_ctrl
    import epsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_issued, r_ainf, r_tinf, r_keep, r_phase, r_fault, r_out_valid;
    logic   is_op, accept, slot_free;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (accept) n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_sts.md_lt2 || i_sts.k_zero || i_sts.pinf) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_RED_A;
                end
            end
            ST_RED_A:   if (i_sts.done) n_state = ST_RED_X;
            ST_RED_X:   if (i_sts.done) n_state = ST_RED_Y;
            ST_RED_Y:   if (i_sts.done) n_state = ST_FIND;
            ST_FIND:    if (i_sts.k_msb) n_state = ST_INIT_X;
            ST_INIT_X:  if (i_sts.done) n_state = ST_INIT_Y;
            ST_INIT_Y:  if (i_sts.done) n_state = ST_BIT;
            ST_BIT:     n_state = i_sts.kcnt_zero ? ST_OUT : ST_DBL_X;
            ST_DBL_X:   if (i_sts.done) n_state = ST_DBL_Y;
            ST_DBL_Y:   if (i_sts.done) n_state = ST_PA_0;
            ST_ADD_X:   if (i_sts.done) n_state = ST_ADD_Y;
            ST_ADD_Y:   if (i_sts.done) n_state = ST_PA_0;
            ST_PA_0: begin
                if (r_ainf) begin
                    n_state = r_keep ? ST_TAKE_X : ST_PA_END;
                end else if (r_tinf) begin
                    n_state = ST_PA_END;
                end else if (i_sts.eq_x) begin
                    n_state = ST_EQ_SUM;
                end else begin
                    n_state = ST_CH_S1;
                end
            end
            ST_TAKE_X:  if (i_sts.done) n_state = ST_TAKE_Y;
            ST_TAKE_Y:  if (i_sts.done) n_state = ST_PA_END;
            ST_EQ_SUM:  if (i_sts.done) n_state = ST_EQ_CHK;
            ST_EQ_CHK: begin
                if (i_sts.t0_zero || !i_sts.eq_y) begin
                    n_state = ST_PA_END;
                end else begin
                    n_state = ST_DB_M1;
                end
            end
            ST_DB_M1:   if (i_sts.done) n_state = ST_DB_M2;
            ST_DB_M2:   if (i_sts.done) n_state = ST_DB_A;
            ST_DB_A:    if (i_sts.done) n_state = ST_DB_Y2;
            ST_DB_Y2:   if (i_sts.done) n_state = ST_INV_0;
            ST_CH_S1:   if (i_sts.done) n_state = ST_CH_S2;
            ST_CH_S2:   if (i_sts.done) n_state = ST_INV_0;
            ST_INV_0:   if (i_sts.done) n_state = ST_INV_1;
            ST_INV_1:   if (i_sts.done) n_state = ST_INV_2;
            ST_INV_2:   if (i_sts.done) n_state = ST_INV_3;
            ST_INV_3:   if (i_sts.done) n_state = ST_INV_LOOP;
            ST_INV_LOOP: n_state = i_sts.r2_zero ? ST_INV_END : ST_INV_DIV;
            ST_INV_DIV: if (i_sts.done) n_state = ST_INV_R1;
            ST_INV_R1:  if (i_sts.done) n_state = ST_INV_R2;
            ST_INV_R2:  if (i_sts.done) n_state = ST_INV_Q;
            ST_INV_Q:   if (i_sts.done) n_state = ST_INV_M;
            ST_INV_M:   if (i_sts.done) n_state = ST_INV_S;
            ST_INV_S:   if (i_sts.done) n_state = ST_INV_U1;
            ST_INV_U1:  if (i_sts.done) n_state = ST_INV_U2;
            ST_INV_U2:  if (i_sts.done) n_state = ST_INV_LOOP;
            ST_INV_END: if (i_sts.done) n_state = ST_LAM;
            ST_LAM:     if (i_sts.done) n_state = ST_X1;
            ST_X1:      if (i_sts.done) n_state = ST_X2;
            ST_X2:      if (i_sts.done) n_state = ST_X3;
            ST_X3:      if (i_sts.done) n_state = ST_Y1;
            ST_Y1:      if (i_sts.done) n_state = ST_Y2;
            ST_Y2:      if (i_sts.done) n_state = ST_Y3;
            ST_Y3:      if (i_sts.done) n_state = r_keep ? ST_PUT_X : ST_PA_END;
            ST_PUT_X:   if (i_sts.done) n_state = ST_PUT_Y;
            ST_PUT_Y:   if (i_sts.done) n_state = ST_PA_END;
            ST_PA_END:  n_state = r_phase ? ST_BIT : ST_ADD_X;
            ST_OUT:     if (slot_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = OP_MOV;
        o_cmd.a         = SEL_ZERO;
        o_cmd.b         = SEL_ZERO;
        o_cmd.dst       = SEL_T2;
        o_cmd.load      = accept;
        o_cmd.res_inf   = r_ainf;
        o_cmd.res_fault = r_fault;
        is_op           = 1'b1;
        case (r_state)
            ST_RED_A:   begin o_cmd.op = OP_DIV; o_cmd.a = SEL_ARED; o_cmd.b = SEL_MD;
                              o_cmd.dst = SEL_ARED; end
            ST_RED_X:   begin o_cmd.op = OP_DIV; o_cmd.a = SEL_BX; o_cmd.b = SEL_MD;
                              o_cmd.dst = SEL_BX; end
            ST_RED_Y:   begin o_cmd.op = OP_DIV; o_cmd.a = SEL_BY; o_cmd.b = SEL_MD;
                              o_cmd.dst = SEL_BY; end
            ST_INIT_X:  begin o_cmd.a = SEL_BX; o_cmd.dst = SEL_AX; end
            ST_INIT_Y:  begin o_cmd.a = SEL_BY; o_cmd.dst = SEL_AY; end
            ST_DBL_X:   begin o_cmd.a = SEL_AX; o_cmd.dst = SEL_TX; end
            ST_DBL_Y:   begin o_cmd.a = SEL_AY; o_cmd.dst = SEL_TY; end
            ST_ADD_X:   begin o_cmd.a = SEL_BX; o_cmd.dst = SEL_TX; end
            ST_ADD_Y:   begin o_cmd.a = SEL_BY; o_cmd.dst = SEL_TY; end
            ST_TAKE_X:  begin o_cmd.a = SEL_TX; o_cmd.dst = SEL_AX; end
            ST_TAKE_Y:  begin o_cmd.a = SEL_TY; o_cmd.dst = SEL_AY; end
            ST_EQ_SUM:  begin o_cmd.op = OP_ADD; o_cmd.a = SEL_AY; o_cmd.b = SEL_TY;
                              o_cmd.dst = SEL_T0; end
            ST_DB_M1:   begin o_cmd.op = OP_MUL; o_cmd.a = SEL_AX; o_cmd.b = SEL_AX;
                              o_cmd.dst = SEL_T0; end
            ST_DB_M2:   begin o_cmd.op = OP_MUL; o_cmd.a = SEL_THREE; o_cmd.b = SEL_T0;
                              o_cmd.dst = SEL_T0; end
            ST_DB_A:    begin o_cmd.op = OP_ADD; o_cmd.a = SEL_T0; o_cmd.b = SEL_ARED;
                              o_cmd.dst = SEL_T0; end
            ST_DB_Y2:   begin o_cmd.op = OP_ADD; o_cmd.a = SEL_AY; o_cmd.b = SEL_AY;
                              o_cmd.dst = SEL_T1; end
            ST_CH_S1:   begin o_cmd.op = OP_SUB; o_cmd.a = SEL_TY; o_cmd.b = SEL_AY;
                              o_cmd.dst = SEL_T0; end
            ST_CH_S2:   begin o_cmd.op = OP_SUB; o_cmd.a = SEL_TX; o_cmd.b = SEL_AX;
                              o_cmd.dst = SEL_T1; end
            ST_INV_0:   begin o_cmd.a = SEL_MD; o_cmd.dst = SEL_R1; end
            ST_INV_1:   begin o_cmd.a = SEL_T1; o_cmd.dst = SEL_R2; end
            ST_INV_2:   begin o_cmd.a = SEL_ZERO; o_cmd.dst = SEL_U1; end
            ST_INV_3:   begin o_cmd.a = SEL_ONE; o_cmd.dst = SEL_U2; end
            ST_INV_DIV: begin o_cmd.op = OP_DIV; o_cmd.a = SEL_R1; o_cmd.b = SEL_R2;
                              o_cmd.dst = SEL_T2; end
            ST_INV_R1:  begin o_cmd.a = SEL_R2; o_cmd.dst = SEL_R1; end
            ST_INV_R2:  begin o_cmd.a = SEL_T2; o_cmd.dst = SEL_R2; end
            ST_INV_Q:   begin o_cmd.op = OP_QRED; o_cmd.a = SEL_Q; o_cmd.dst = SEL_Q; end
            ST_INV_M:   begin o_cmd.op = OP_MUL; o_cmd.a = SEL_Q; o_cmd.b = SEL_U2;
                              o_cmd.dst = SEL_T2; end
            ST_INV_S:   begin o_cmd.op = OP_SUB; o_cmd.a = SEL_U1; o_cmd.b = SEL_T2;
                              o_cmd.dst = SEL_T2; end
            ST_INV_U1:  begin o_cmd.a = SEL_U2; o_cmd.dst = SEL_U1; end
            ST_INV_U2:  begin o_cmd.a = SEL_T2; o_cmd.dst = SEL_U2; end
            ST_INV_END: begin o_cmd.a = SEL_U1; o_cmd.dst = SEL_T1; end
            ST_LAM:     begin o_cmd.op = OP_MUL; o_cmd.a = SEL_T0; o_cmd.b = SEL_T1;
                              o_cmd.dst = SEL_LAM; end
            ST_X1:      begin o_cmd.op = OP_MUL; o_cmd.a = SEL_LAM; o_cmd.b = SEL_LAM;
                              o_cmd.dst = SEL_T0; end
            ST_X2:      begin o_cmd.op = OP_SUB; o_cmd.a = SEL_T0; o_cmd.b = SEL_AX;
                              o_cmd.dst = SEL_T0; end
            ST_X3:      begin o_cmd.op = OP_SUB; o_cmd.a = SEL_T0; o_cmd.b = SEL_TX;
                              o_cmd.dst = SEL_T0; end
            ST_Y1:      begin o_cmd.op = OP_SUB; o_cmd.a = SEL_AX; o_cmd.b = SEL_T0;
                              o_cmd.dst = SEL_T1; end
            ST_Y2:      begin o_cmd.op = OP_MUL; o_cmd.a = SEL_LAM; o_cmd.b = SEL_T1;
                              o_cmd.dst = SEL_T1; end
            ST_Y3:      begin o_cmd.op = OP_SUB; o_cmd.a = SEL_T1; o_cmd.b = SEL_AY;
                              o_cmd.dst = SEL_T1; end
            ST_PUT_X:   begin o_cmd.a = SEL_T0; o_cmd.dst = SEL_AX; end
            ST_PUT_Y:   begin o_cmd.a = SEL_T1; o_cmd.dst = SEL_AY; end
            ST_FIND: begin
                is_op         = 1'b0;
                o_cmd.k_shift = !i_sts.k_msb;
            end
            ST_BIT: begin
                is_op         = 1'b0;
                o_cmd.k_shift = !i_sts.kcnt_zero;
            end
            ST_OUT: begin
                is_op         = 1'b0;
                o_cmd.capture = slot_free;
            end
            default:    is_op = 1'b0;
        endcase
        o_cmd.go = is_op && !r_issued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_ainf      <= 1'b0;
            r_tinf      <= 1'b0;
            r_keep      <= 1'b0;
            r_phase     <= 1'b0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.go) begin
                r_issued <= 1'b1;
            end else if (i_sts.done) begin
                r_issued <= 1'b0;
            end
            if (o_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CHECK: begin
                    r_fault <= i_sts.md_lt2;
                    r_ainf  <= 1'b1;
                end
                ST_INIT_Y: if (i_sts.done) r_ainf <= 1'b0;
                ST_BIT: begin
                    r_phase <= 1'b0;
                    r_keep  <= 1'b1;
                end
                ST_DBL_Y:  if (i_sts.done) r_tinf <= r_ainf;
                ST_ADD_X:  r_keep <= i_sts.k_msb;
                ST_ADD_Y:  if (i_sts.done) r_tinf <= 1'b0;
                ST_PA_0:   if (r_ainf && r_keep) r_ainf <= r_tinf;
                ST_EQ_CHK: begin
                    if (i_sts.t0_zero || !i_sts.eq_y) begin
                        if (r_keep) r_ainf <= 1'b1;
                        if (!i_sts.t0_zero) r_fault <= 1'b1;
                    end
                end
                ST_PUT_Y:  if (i_sts.done) r_ainf <= 1'b0;
                ST_PA_END: r_phase <= 1'b1;
                default:   ;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.done |-> r_issued)
        else $error("datapath done without an issued operation");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_issued && !i_sts.done))
        else $error("operation pending while idle");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_CHECK))
        else $error("accepted beat did not start a check");

endmodule

/* rtl/ecc_point_scalar_multiply.sv */
// channel  | valid         | ready         | payload
// input    | i_in_valid    | o_in_ready    | i_scalar, i_point_x, i_point_y, i_point_at_infinity
// output   | o_out_valid   | i_out_ready   | o_result_x, o_result_y, o_result_infinity, o_fault
// config   | i_cfg_we      | -             | i_cfg_idx, i_cfg_wdata
// One beat at a time. Multiply and divide run bit-serially; other field ops write in a single step.
// Per scalar bit: two point additions, each about 20 ops plus one inverse of
// up to ~1.45*FIELD_BITS Euclid rounds, all run on the one shared ALU.
// Reset is synchronous, active low; config registers reset to a = 0, p = 3.
// A finished result waits in the output register while the next beat is accepted.
module ecc_point_scalar_multiply
    import epsm_pkg::*;
#(
    parameter int FIELD_BITS  = 32,
    parameter int SCALAR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_scalar,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic        i_point_at_infinity,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_x,
    output logic [31:0] o_result_y,
    output logic        o_result_infinity,
    output logic        o_fault,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    epsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    epsm_dp #(
        .FIELD_BITS  (FIELD_BITS),
        .SCALAR_BITS (SCALAR_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_scalar            (i_scalar),
        .i_point_x           (i_point_x),
        .i_point_y           (i_point_y),
        .i_point_at_infinity (i_point_at_infinity),
        .o_result_x          (o_result_x),
        .o_result_y          (o_result_y),
        .o_result_infinity   (o_result_infinity),
        .o_fault             (o_fault)
    );

endmodule

/* sim/ecc_point_scalar_multiply_tb.sv */
module ecc_point_scalar_multiply_tb;
    import epsm_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;
    localparam logic [31:0] BIG_PRIME = 32'd4294967291;

    typedef struct {
        logic [31:0] scalar;
        logic [31:0] px;
        logic [31:0] py;
        logic        pinf;
    } t_job;

    typedef struct {
        logic [31:0] rx;
        logic [31:0] ry;
        logic        rinf;
        logic        flt;
    } t_point_res;

    typedef struct {
        longint unsigned x;
        longint unsigned y;
        bit              inf;
    } t_pt;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] in_scalar;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic        in_inf;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic        out_inf;
    logic        out_fault;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_wdata;

    ecc_point_scalar_multiply i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_scalar           (in_scalar),
        .i_point_x          (in_x),
        .i_point_y          (in_y),
        .i_point_at_infinity(in_inf),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_result_x         (out_x),
        .o_result_y         (out_y),
        .o_result_infinity  (out_inf),
        .o_fault            (out_fault),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_wdata        (cfg_wdata)
    );

    t_job        pending_jobs[$];
    t_point_res  expected_points[$];
    logic [31:0] model_a;
    logic [31:0] model_p;
    longint unsigned mod_p;
    longint unsigned a_mod;
    bit          saw_fault;
    bit          idle_on;
    int          errors;
    int          jobs_done;
    int          faults_seen;
    int          infs_seen;
    int          phases_run;
    int          in_gap;
    int          out_stall;
    longint unsigned cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned f_add(longint unsigned u, longint unsigned v);
        longint unsigned s;
        s = u + v;
        if (s >= mod_p) s -= mod_p;
        return s;
    endfunction

    function automatic longint unsigned f_sub(longint unsigned u, longint unsigned v);
        return (u >= v) ? (u - v) : (u + (mod_p - v));
    endfunction

    function automatic longint unsigned f_mul(longint unsigned u, longint unsigned v);
        return (u * v) % mod_p;
    endfunction

    function automatic longint unsigned f_inv(longint unsigned v);
        longint unsigned r1, r2, t1, t2, q, r, t;
        r1 = mod_p;
        r2 = v;
        t1 = 0;
        t2 = 1 % mod_p;
        while (r2 > 0) begin
            q  = r1 / r2;
            r  = r1 % r2;
            t  = f_sub(t1, f_mul(q % mod_p, t2));
            r1 = r2;
            r2 = r;
            t1 = t2;
            t2 = t;
        end
        return t1;
    endfunction

    function automatic t_pt point_sum(t_pt s, t_pt t);
        t_pt o;
        longint unsigned lam;
        o.x = 0;
        o.y = 0;
        o.inf = 1'b1;
        if (s.inf) return t;
        if (t.inf) return s;
        if (s.x == t.x) begin
            if (f_add(s.y, t.y) == 0) return o;
            if (s.y != t.y) begin
                saw_fault = 1'b1;
                return o;
            end
            lam = f_add(f_mul(3 % mod_p, f_mul(s.x, s.x)), a_mod);
            lam = f_mul(lam, f_inv(f_add(s.y, s.y)));
        end else begin
            lam = f_mul(f_sub(t.y, s.y), f_inv(f_sub(t.x, s.x)));
        end
        o.inf = 1'b0;
        o.x = f_sub(f_sub(f_mul(lam, lam), s.x), t.x);
        o.y = f_sub(f_mul(lam, f_sub(s.x, o.x)), s.y);
        return o;
    endfunction

    function automatic t_point_res predict_multiply(t_job j);
        t_point_res res;
        t_pt base, acc, junk;
        int top;
        res = '{32'd0, 32'd0, 1'b0, 1'b0};
        mod_p = model_p;
        if (mod_p < 2) begin
            res.flt = 1'b1;
            return res;
        end
        a_mod = model_a % mod_p;
        saw_fault = 1'b0;
        if (j.scalar == 0 || j.pinf) begin
            res.rinf = 1'b1;
            return res;
        end
        base.x = j.px % mod_p;
        base.y = j.py % mod_p;
        base.inf = 1'b0;
        top = 31;
        while (!j.scalar[top]) top--;
        acc = base;
        for (int i = top - 1; i >= 0; i--) begin
            acc = point_sum(acc, acc);
            if (j.scalar[i]) acc = point_sum(acc, base);
            else junk = point_sum(acc, base);
        end
        if (saw_fault) res.flt = 1'b1;
        else if (acc.inf) res.rinf = 1'b1;
        else begin
            res.rx = acc.x[31:0];
            res.ry = acc.y[31:0];
        end
        return res;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (in_valid && in_ready)
                expected_points.push_back(predict_multiply('{in_scalar, in_x, in_y, in_inf}));
            if (!(in_valid && !in_ready)) begin
                if (in_gap != 0) begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_jobs.size() != 0) begin
                    in_scalar <= pending_jobs[0].scalar;
                    in_x      <= pending_jobs[0].px;
                    in_y      <= pending_jobs[0].py;
                    in_inf    <= pending_jobs[0].pinf;
                    void'(pending_jobs.pop_front());
                    in_valid  <= 1'b1;
                    in_gap    <= idle_on ? $urandom_range(0, 4) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_point_res exp_r;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (out_valid && out_ready) begin
                jobs_done++;
                if (out_fault) faults_seen++;
                if (out_inf) infs_seen++;
                if (expected_points.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    exp_r = expected_points.pop_front();
                    if (out_x !== exp_r.rx) begin
                        $error("result_x expected %h got %h", exp_r.rx, out_x);
                        errors++;
                    end
                    if (out_y !== exp_r.ry) begin
                        $error("result_y expected %h got %h", exp_r.ry, out_y);
                        errors++;
                    end
                    if (out_inf !== exp_r.rinf) begin
                        $error("result_infinity expected %b got %b", exp_r.rinf, out_inf);
                        errors++;
                    end
                    if (out_fault !== exp_r.flt) begin
                        $error("fault expected %b got %b", exp_r.flt, out_fault);
                        errors++;
                    end
                end
                if (idle_on && $urandom_range(0, 4) != 0) begin
                    out_ready <= 1'b0;
                    out_stall <= $urandom_range(1, 4);
                end
            end else if (!out_ready) begin
                if (out_stall <= 1) out_ready <= 1'b1;
                out_stall <= out_stall - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_jobs.size() != 0 || in_valid || out_valid ||
                   expected_points.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        if (idx == CFG_CURVE_A) model_a = val;
        else model_p = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_curve(logic [31:0] a, logic [31:0] p);
        wait_idle();
        write_reg(CFG_CURVE_A, a);
        write_reg(CFG_PRIME, p);
        phases_run++;
        idle_on = ($urandom_range(0, 3) != 0);
        @(negedge i_clk);
    endtask

    task automatic add_job(logic [31:0] k, logic [31:0] x, logic [31:0] y, logic inf);
        pending_jobs.push_back('{k, x, y, inf});
    endtask

    initial begin
        logic [31:0] p, k;
        int sel;
        errors = 0;
        jobs_done = 0;
        faults_seen = 0;
        infs_seen = 0;
        phases_run = 0;
        cycles = 0;
        idle_on = 1'b1;
        model_a = 32'd0;
        model_p = 32'd3;
        in_valid = 1'b0;
        in_scalar = '0;
        in_x = '0;
        in_y = '0;
        in_inf = 1'b0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_CURVE_A;
        cfg_wdata = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset curve: a = 0, p = 3
        add_job(32'd1, 32'd1, 32'd1, 1'b0);
        add_job(32'hFFFFFFFF, 32'd2, 32'd2, 1'b0);
        add_job(32'd0, 32'd1, 32'd1, 1'b0);
        add_job(32'd5, 32'd1, 32'd1, 1'b1);

        set_curve(32'd2, 32'd17);
        add_job(32'd1, 32'd5, 32'd1, 1'b0);
        add_job(32'd2, 32'd5, 32'd1, 1'b0);
        add_job(32'd19, 32'd5, 32'd1, 1'b0);
        add_job(32'd2, 32'd3, 32'd0, 1'b0);
        add_job(32'd3, 32'd3, 32'd17, 1'b0);
        add_job(32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        add_job(32'hFFFFFFFF, 32'h0, 32'h5, 1'b1);

        set_curve(32'hFFFFFFFF, 32'd0);
        add_job(32'd7, 32'd1, 32'd2, 1'b0);
        add_job(32'd0, 32'd1, 32'd2, 1'b1);
        set_curve(32'd0, 32'd1);
        add_job(32'd3, 32'd1, 32'd2, 1'b0);

        set_curve(32'hFFFFFFFF, BIG_PRIME);
        add_job(32'd3, 32'hFFFFFFFF, 32'h00000000, 1'b0);
        add_job(32'd6, 32'h12345678, 32'h9ABCDEF0, 1'b0);
        add_job($urandom, $urandom, $urandom, 1'b0);

        set_curve(32'd4, 32'd15);
        add_job(32'd11, 32'd2, 32'd7, 1'b0);
        set_curve(32'd1, 32'd2);
        add_job(32'd6, 32'd1, 32'd1, 1'b0);
        add_job(32'd3, 32'd0, 32'd1, 1'b0);

        for (int ph = 0; ph < 7; ph++) begin
            sel = $urandom_range(0, 7);
            case (sel)
                0: p = 32'd5;
                1: p = 32'd7;
                2: p = 32'd13;
                3: p = 32'd97;
                4: p = 32'd251;
                5: p = 32'd65521;
                6: p = BIG_PRIME;
                default: p = $urandom_range(2, 5000);
            endcase
            set_curve($urandom_range(0, 1) ? $urandom : $urandom_range(0, 10), p);
            for (int n = 0; n < 11; n++) begin
                if (p < 70000 && $urandom_range(0, 7) == 0) k = $urandom;
                else k = $urandom_range(0, 63);
                add_job(k, $urandom, $urandom, $urandom_range(0, 15) == 0);
            end
        end

        wait_idle();
        $display("%0d multiplications checked over %0d curve settings", jobs_done, phases_run);
        $display("%0d infinity results, %0d faulted results", infs_seen, faults_seen);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
